// ===== rtl/unix_seconds_to_civil_datetime_macros.svh =====
// Assertion macros shared by the checkers of the civil date converter.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef UNIX_SECONDS_TO_CIVIL_DATETIME_MACROS_SVH
`define UNIX_SECONDS_TO_CIVIL_DATETIME_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USCCD_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("usccd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define USCCD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("usccd assertion failed");

`endif

// ===== rtl/usccd_pkg.sv =====
// Shared types and constants of the civil date converter pipeline.
// Depends on nothing; imported by every module of the block.
package usccd_pkg;

   localparam int NUM_STAGES = 11;

   typedef logic [NUM_STAGES:1] stage_en_type;

   typedef struct packed {
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } tod_type;

   localparam logic [63:0] SECS_LIMIT       = 64'd253402300800;
   localparam logic [21:0] EPOCH_SHIFT_DAYS = 22'd719468;
   localparam logic [21:0] DAYS_PER_ERA     = 22'd146097;
   localparam logic [9:0]  DAY_ODD_FACTOR   = 10'd675;   // 86400 = 675 * 128
   localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
   localparam logic [11:0] SECS_PER_MIN     = 12'd60;
   localparam logic [17:0] DAYS_PER_YEAR    = 18'd365;

   // Reciprocals rounded up; the shift is chosen so the quotient is exact
   // over the whole range of the dividend at each place of use.
   localparam logic [31:0] RECIP_675    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
   localparam logic [22:0] RECIP_ERA    = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
   localparam logic [17:0] RECIP_3600   = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
   localparam logic [12:0] RECIP_60     = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
   localparam logic [18:0] RECIP_1460   = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
   localparam logic [18:0] RECIP_365    = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
   localparam logic [11:0] RECIP_153    = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

   // Day of the March-based year on which each month starts.
   function automatic logic [8:0] days_before_month(input logic [3:0] mp);
      logic [8:0] start;
      case (mp)
         4'd0:    start = 9'd0;
         4'd1:    start = 9'd31;
         4'd2:    start = 9'd61;
         4'd3:    start = 9'd92;
         4'd4:    start = 9'd122;
         4'd5:    start = 9'd153;
         4'd6:    start = 9'd184;
         4'd7:    start = 9'd214;
         4'd8:    start = 9'd245;
         4'd9:    start = 9'd275;
         4'd10:   start = 9'd306;
         4'd11:   start = 9'd337;
         default: start = 9'd0;
      endcase
      return start;
   endfunction

endpackage

// ===== rtl/usccd_daysplit.sv =====
// Pipeline stages one to three: splits the seconds count into whole days
// and seconds of the day. Depends on usccd_pkg.
module usccd_daysplit import usccd_pkg::*; (
   input  logic         clock,
   input  stage_en_type en,
   input  logic [37:0]  seconds,
   output logic [16:0]  day_secs,
   output logic [21:0]  shifted_days
);

   logic [30:0] x1_ff;
   logic [6:0]  lo1_ff;
   logic [30:0] x2_ff;
   logic [6:0]  lo2_ff;
   logic [21:0] days2_ff;
   logic [16:0] rem3_ff;
   logic [21:0] z3_ff;

   logic [62:0] days_prod;
   logic [21:0] days2_in;
   logic [31:0] days_scaled;
   logic [30:0] rx_full;
   logic [16:0] rem3_in;
   logic [21:0] z3_in;

   // The low seven bits of 86400 are a power of two, so only 675 is divided.
   assign days_prod = {32'd0, x1_ff} * {31'd0, RECIP_675};
   assign days2_in  = days_prod[62:41];

   assign days_scaled = {10'd0, days2_ff} * {22'd0, DAY_ODD_FACTOR};
   assign rx_full     = x2_ff - days_scaled[30:0];
   assign rem3_in     = {rx_full[9:0], lo2_ff};
   assign z3_in       = days2_ff + EPOCH_SHIFT_DAYS;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         x1_ff  <= seconds[37:7];
         lo1_ff <= seconds[6:0];
      end
      if (en[2]) begin
         x2_ff    <= x1_ff;
         lo2_ff   <= lo1_ff;
         days2_ff <= days2_in;
      end
      if (en[3]) begin
         rem3_ff <= rem3_in;
         z3_ff   <= z3_in;
      end
   end

   assign day_secs     = rem3_ff;
   assign shifted_days = z3_ff;

endmodule

// ===== rtl/usccd_clock.sv =====
// Pipeline stages four to ten for the time of day: hour, minute and second
// from the seconds of the day. Depends on usccd_pkg.
module usccd_clock import usccd_pkg::*; (
   input  logic         clock,
   input  stage_en_type en,
   input  logic [16:0]  day_secs,
   output tod_type      tod
);

   logic [16:0] rem4_ff;
   logic [4:0]  hour4_ff;
   logic [11:0] r5_ff;
   logic [4:0]  hour5_ff;
   logic [11:0] r6_ff;
   logic [4:0]  hour6_ff;
   logic [5:0]  minute6_ff;
   tod_type     tod_ff [7:10];

   logic [34:0] hour_prod;
   logic [4:0]  hour4_in;
   logic [16:0] hour_secs;
   logic [11:0] r5_in;
   logic [24:0] minute_prod;
   logic [5:0]  minute6_in;
   logic [11:0] minute_secs;
   logic [11:0] sec_full;
   tod_type     tod7_in;

   assign hour_prod = {18'd0, day_secs} * {17'd0, RECIP_3600};
   assign hour4_in  = hour_prod[33:29];

   assign hour_secs = {12'd0, hour4_ff} * {5'd0, SECS_PER_HOUR};
   assign r5_in     = 12'(rem4_ff - hour_secs);

   assign minute_prod = {13'd0, r5_ff} * {12'd0, RECIP_60};
   assign minute6_in  = minute_prod[23:18];

   assign minute_secs    = {6'd0, minute6_ff} * SECS_PER_MIN;
   assign sec_full       = r6_ff - minute_secs;
   assign tod7_in.hour   = hour6_ff;
   assign tod7_in.minute = minute6_ff;
   assign tod7_in.second = sec_full[5:0];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rem4_ff  <= day_secs;
         hour4_ff <= hour4_in;
      end
      if (en[5]) begin
         r5_ff    <= r5_in;
         hour5_ff <= hour4_ff;
      end
      if (en[6]) begin
         r6_ff      <= r5_ff;
         hour6_ff   <= hour5_ff;
         minute6_ff <= minute6_in;
      end
      if (en[7]) begin
         tod_ff[7] <= tod7_in;
      end
      // The time of day is ready early and waits for the date path.
      for (int i = 8; i <= 10; i++) begin
         if (en[i]) begin
            tod_ff[i] <= tod_ff[i-1];
         end
      end
   end

   assign tod = tod_ff[10];

endmodule

// ===== rtl/usccd_civil.sv =====
// Pipeline stages four to ten for the date: era, year of era, day of year
// and month from the shifted day count. Depends on usccd_pkg.
module usccd_civil import usccd_pkg::*; (
   input  logic         clock,
   input  stage_en_type en,
   input  logic [21:0]  shifted_days,
   output logic [13:0]  year,
   output logic [3:0]   month,
   output logic [4:0]   day
);

   logic [21:0] z4_ff;
   logic [4:0]  era4_ff;
   logic [17:0] doe5_ff;
   logic [4:0]  era5_ff;
   logic [17:0] doe6_ff;
   logic [6:0]  q1460_6_ff;
   logic [2:0]  q36524_6_ff;
   logic        last6_ff;
   logic [4:0]  era6_ff;
   logic [17:0] v7_ff;
   logic [17:0] doe7_ff;
   logic [4:0]  era7_ff;
   logic [8:0]  yoe8_ff;
   logic [17:0] doe8_ff;
   logic [4:0]  era8_ff;
   logic [8:0]  doy9_ff;
   logic [8:0]  yoe9_ff;
   logic [4:0]  era9_ff;
   logic [3:0]  mp10_ff;
   logic [8:0]  doy10_ff;
   logic [8:0]  yoe10_ff;
   logic [4:0]  era10_ff;

   logic [44:0] era_prod;
   logic [4:0]  era4_in;
   logic [21:0] era_days;
   logic [21:0] doe_full;
   logic [36:0] q1460_prod;
   logic [6:0]  q1460_6_in;
   logic [2:0]  q36524_6_in;
   logic [17:0] v7_in;
   logic [36:0] yoe_prod;
   logic [8:0]  yoe8_in;
   logic [1:0]  q100;
   logic [17:0] year_days;
   logic [17:0] doy_full;
   logic [10:0] mp_num;
   logic [22:0] mp_prod;
   logic [3:0]  mp10_in;
   logic [8:0]  month_start;
   logic [8:0]  dom_full;
   logic        jan_feb;
   logic [13:0] era_years;

   // Stage four: era of 400 years.
   assign era_prod = {23'd0, shifted_days} * {22'd0, RECIP_ERA};
   assign era4_in  = era_prod[44:40];

   // Stage five: day of era.
   assign era_days = {17'd0, era4_ff} * DAYS_PER_ERA;
   assign doe_full = z4_ff - era_days;

   // Stage six: leap corrections of the day of era.
   assign q1460_prod  = {19'd0, doe5_ff} * {18'd0, RECIP_1460};
   assign q1460_6_in  = q1460_prod[35:29];
   assign q36524_6_in = 3'(doe5_ff >= 18'd36524) + 3'(doe5_ff >= 18'd73048)
                      + 3'(doe5_ff >= 18'd109572) + 3'(doe5_ff >= 18'd146096);

   // Stage seven: day of era with the leap days taken out.
   assign v7_in = doe6_ff - {11'd0, q1460_6_ff} + {15'd0, q36524_6_ff}
                - {17'd0, last6_ff};

   // Stage eight: year of era.
   assign yoe_prod = {19'd0, v7_ff} * {18'd0, RECIP_365};
   assign yoe8_in  = yoe_prod[35:27];

   // Stage nine: day of the March-based year.
   assign q100      = 2'(yoe8_ff >= 9'd100) + 2'(yoe8_ff >= 9'd200)
                    + 2'(yoe8_ff >= 9'd300);
   assign year_days = {9'd0, yoe8_ff} * DAYS_PER_YEAR + {11'd0, yoe8_ff[8:2]}
                    - {16'd0, q100};
   assign doy_full  = doe8_ff - year_days;

   // Stage ten: month counted from March.
   assign mp_num  = {2'd0, doy9_ff} * 11'd5 + 11'd2;
   assign mp_prod = {12'd0, mp_num} * {11'd0, RECIP_153};
   assign mp10_in = mp_prod[22:19];

   // Calendar fields, registered by the output stage.
   assign month_start = days_before_month(mp10_ff);
   assign dom_full    = doy10_ff - month_start + 9'd1;
   assign day         = dom_full[4:0];
   assign month       = (mp10_ff < 4'd10) ? mp10_ff + 4'd3 : mp10_ff - 4'd9;
   assign jan_feb     = (mp10_ff >= 4'd10);
   assign era_years   = {9'd0, era10_ff} * 14'd400;
   assign year        = {5'd0, yoe10_ff} + era_years + {13'd0, jan_feb};

   always_ff @(posedge clock) begin
      if (en[4]) begin
         z4_ff   <= shifted_days;
         era4_ff <= era4_in;
      end
      if (en[5]) begin
         doe5_ff <= doe_full[17:0];
         era5_ff <= era4_ff;
      end
      if (en[6]) begin
         doe6_ff     <= doe5_ff;
         q1460_6_ff  <= q1460_6_in;
         q36524_6_ff <= q36524_6_in;
         last6_ff    <= (doe5_ff == 18'd146096);
         era6_ff     <= era5_ff;
      end
      if (en[7]) begin
         v7_ff   <= v7_in;
         doe7_ff <= doe6_ff;
         era7_ff <= era6_ff;
      end
      if (en[8]) begin
         yoe8_ff <= yoe8_in;
         doe8_ff <= doe7_ff;
         era8_ff <= era7_ff;
      end
      if (en[9]) begin
         doy9_ff <= doy_full[8:0];
         yoe9_ff <= yoe8_ff;
         era9_ff <= era8_ff;
      end
      if (en[10]) begin
         mp10_ff  <= mp10_in;
         doy10_ff <= doy9_ff;
         yoe10_ff <= yoe9_ff;
         era10_ff <= era9_ff;
      end
   end

endmodule

// ===== rtl/unix_seconds_to_civil_datetime.sv =====
// Converts a signed count of seconds since the Unix epoch to a Gregorian
// date and time of day. Depends on usccd_pkg, usccd_daysplit, usccd_clock
// and usccd_civil.
//
// Usage: present a timestamp on req_unix_seconds with req_valid; it is taken
// at a rising edge with req_valid and req_ready both high. The result item
// appears on the rsp_ ports with rsp_valid and is taken when rsp_ready is
// high. Timestamps below zero or at or beyond the year 10000 give
// rsp_out_of_range high and all other result fields zero.
// The pipeline has eleven register stages, each holding at most one constant
// reciprocal multiply per path (time or date), and takes one item every cycle
// while results flow.
// When the receiver stalls, the output register holds its item and the
// stages behind it keep filling bubbles; req_ready drops only once every
// stage holds an item. Reset empties the pipeline; no item is lost or
// repeated across a stall.
module unix_seconds_to_civil_datetime import usccd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [63:0] req_unix_seconds,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [13:0]        rsp_year,
   output logic [3:0]         rsp_month,
   output logic [4:0]         rsp_day,
   output logic [4:0]         rsp_hour,
   output logic [5:0]         rsp_minute,
   output logic [5:0]         rsp_second,
   output logic               rsp_out_of_range
);

   stage_en_type             en;
   logic [NUM_STAGES:1]      valid_ff;
   logic [NUM_STAGES-1:1]    oor_ff;
   logic [63:0]              secs;
   logic                     oor_in;
   logic [16:0]              day_secs;
   logic [21:0]              shifted_days;
   tod_type                  tod;
   logic [13:0]              year;
   logic [3:0]               month;
   logic [4:0]               day;

   logic [13:0]              year_ff;
   logic [3:0]               month_ff;
   logic [4:0]               day_ff;
   tod_type                  tod_ff;
   logic                     oor_out_ff;

   // A stage may load when it is empty or its item moves on this cycle.
   always_comb begin
      en[NUM_STAGES] = !valid_ff[NUM_STAGES] || rsp_ready;
      for (int i = NUM_STAGES - 1; i >= 1; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[1];

   assign secs   = $unsigned(req_unix_seconds);
   assign oor_in = secs[63] || (secs >= SECS_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NUM_STAGES; i++) begin
            if (en[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         oor_ff[1] <= oor_in;
      end
      for (int i = 2; i <= NUM_STAGES - 1; i++) begin
         if (en[i]) begin
            oor_ff[i] <= oor_ff[i-1];
         end
      end
   end

   usccd_daysplit u_daysplit (
      .clock        (clock),
      .en           (en),
      .seconds      (secs[37:0]),
      .day_secs     (day_secs),
      .shifted_days (shifted_days)
   );

   usccd_clock u_clock (
      .clock    (clock),
      .en       (en),
      .day_secs (day_secs),
      .tod      (tod)
   );

   usccd_civil u_civil (
      .clock        (clock),
      .en           (en),
      .shifted_days (shifted_days),
      .year         (year),
      .month        (month),
      .day          (day)
   );

   // Output stage: rejected items leave with every field cleared.
   always_ff @(posedge clock) begin
      if (en[NUM_STAGES]) begin
         oor_out_ff <= oor_ff[NUM_STAGES-1];
         if (oor_ff[NUM_STAGES-1]) begin
            year_ff  <= '0;
            month_ff <= '0;
            day_ff   <= '0;
            tod_ff   <= '0;
         end else begin
            year_ff  <= year;
            month_ff <= month;
            day_ff   <= day;
            tod_ff   <= tod;
         end
      end
   end

   assign rsp_valid        = valid_ff[NUM_STAGES];
   assign rsp_year         = year_ff;
   assign rsp_month        = month_ff;
   assign rsp_day          = day_ff;
   assign rsp_hour         = tod_ff.hour;
   assign rsp_minute       = tod_ff.minute;
   assign rsp_second       = tod_ff.second;
   assign rsp_out_of_range = oor_out_ff;

endmodule

// ===== rtl/usccd_checker.sv =====
// Port-level checks on the civil date converter, bound to its top level.
// Depends on unix_seconds_to_civil_datetime_macros.svh.
`include "unix_seconds_to_civil_datetime_macros.svh"

module usccd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic signed [63:0] req_unix_seconds,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [13:0]        rsp_year,
   input logic [3:0]         rsp_month,
   input logic [4:0]         rsp_day,
   input logic [4:0]         rsp_hour,
   input logic [5:0]         rsp_minute,
   input logic [5:0]         rsp_second,
   input logic               rsp_out_of_range
);

   // A stalled result item keeps its place, and its year, month, day and second stay stable.
   `USCCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_year) && $stable(rsp_month) && $stable(rsp_day) && $stable(rsp_second))

   // A rejected timestamp carries no date or time.
   `USCCD_ASSERT_SAME(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_year == 14'd0 && rsp_month == 4'd0 && rsp_day == 5'd0 && rsp_hour == 5'd0 && rsp_minute == 6'd0 && rsp_second == 6'd0)

   // An accepted timestamp yields fields in their legal ranges, with the year from 1970 to 9999.
   `USCCD_ASSERT_SAME(a_fields_legal, clock, reset, rsp_valid && !rsp_out_of_range, rsp_year >= 14'd1970 && rsp_year <= 14'd9999 && rsp_month >= 4'd1 && rsp_month <= 4'd12 && rsp_day >= 5'd1 && rsp_day <= 5'd31 && rsp_hour <= 5'd23 && rsp_minute <= 6'd59 && rsp_second <= 6'd59)

   // Reset leaves no result item behind.
   `USCCD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind unix_seconds_to_civil_datetime usccd_checker u_usccd_checker (.*);
